// ----- rtl/core/spcf_pkg.sv -----
package spcf_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_EPS      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_FSCALE   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_IPM      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_IBM      = 3'd6;

  localparam logic [30:0] CFG_ONE_RST = 31'd65536;

  // ln(2) in Q.24
  localparam logic [31:0] LN2_Q24 = 32'd11629080;
  localparam logic [31:0] CAP_MUL = 32'd10000;
  // log difference is in Q.(F+4), LN2 in Q.24, halved for the square root
  localparam int unsigned LN_SHIFT = 29;

  typedef logic [31:0] word_t;
  typedef logic [32:0] eta_t;

endpackage

// ----- rtl/core/sphere_particle_contact_force_unit.sv -----
// Sphere contact force unit (logarithmic penalty).
// Input stream (in_*): one particle per request, positions and accelerations
// in tdata, the last particle of a pass on tlast. Output stream (out_*): one
// result per particle with corrected accelerations and the running body
// acceleration sums; tlast repeats the input tlast.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the sphere center, contact
// distance, force scale and inverse masses; write only while idle.
// Sequence: a particle outside the contact box goes from the box check to the
// final step (after the squares when only the squared distance test rejects
// it). A particle in contact runs through one shared 32x32 multiplier and a
// shared add/compare path: squares, two logarithms of FRAC_BITS+4 squaring
// rounds each, a 32-step square root and three FRAC_BITS-step divisions.
// One particle is in work at a time; in_tready is high only when the
// sequencer is idle.
// The output register holds a result until out_tready; a new particle is
// accepted meanwhile, and its result waits in the final step if the output
// register is still full.
// Reset clears the body sums and the output valid and loads the register
// defaults (center 0, the others 1.0). Body sums clear after the result of
// the last particle of a pass is formed.
module sphere_particle_contact_force_unit
  import spcf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SUM_BITS  = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x, pos_y, pos_z, acc_in_x, acc_in_y, acc_in_z
  input  logic [191:0]          in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // acc_out_x, acc_out_y, acc_out_z, body_acc_x, body_acc_y, body_acc_z
  output logic [239:0]          out_tdata,
  output logic                  out_tlast
);

  localparam int unsigned LOG_FRAC = FRAC_BITS + 4;
  localparam int unsigned LW       = LOG_FRAC + 6;
  localparam int unsigned QW       = FRAC_BITS + 1;

  localparam logic signed [65:0] SUM_HI = (66'sd1 <<< (SUM_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] SUM_LO = -SUM_HI - 66'sd1;
  localparam logic signed [65:0] OUT_HI = 66'sh7FFF_FFFF_FFFF;
  localparam logic signed [65:0] OUT_LO = -OUT_HI - 66'sd1;
  localparam logic signed [65:0] ACC_HI = 66'sh7FFF_FFFF;
  localparam logic signed [65:0] ACC_LO = -ACC_HI - 66'sd1;
  localparam logic [95:0]        PCAP   = 96'd1 << 62;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_EPS  = 4'd3;
  localparam logic [3:0] S_NORM = 4'd4;
  localparam logic [3:0] S_LSQ  = 4'd5;
  localparam logic [3:0] S_LN   = 4'd6;
  localparam logic [3:0] S_FRC  = 4'd7;
  localparam logic [3:0] S_CAP  = 4'd8;
  localparam logic [3:0] S_SQRT = 4'd9;
  localparam logic [3:0] S_DIVI = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_T    = 4'd12;
  localparam logic [3:0] S_DP   = 4'd13;
  localparam logic [3:0] S_DB   = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  function automatic logic [32:0] mag_f(input eta_t e);
    return e[32] ? 33'(-e) : e;
  endfunction

  function automatic logic [62:0] sat_f(input logic [95:0] p);
    logic [95:0] v;
    v = p >> FRAC_BITS;
    return (v > PCAP) ? PCAP[62:0] : v[62:0];
  endfunction

  function automatic logic signed [65:0] clamp_f(input logic signed [65:0] v,
                                                input logic signed [65:0] hi,
                                                input logic signed [65:0] lo);
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // configuration
  word_t       center_r [3];
  logic [30:0] eps_r, fscale_r, ipm_r, ibm_r;

  // sequencer and datapath
  logic [3:0]  state_r, state_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        lsel_r, lsel_nxt;
  logic        last_r, last_nxt;
  eta_t        eta_r [3];
  eta_t        eta_nxt [3];
  word_t       acc_r [3];
  word_t       acc_nxt [3];
  logic signed [SUM_BITS-1:0] sum_r [3];
  logic signed [SUM_BITS-1:0] sum_nxt [3];
  logic [63:0] d2_r, d2_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] r_r, r_nxt;
  logic [5:0]  nsh_r, nsh_nxt;
  word_t       m_r, m_nxt;
  logic [LW-1:0] lr_r, lr_nxt;
  logic [LW-1:0] le_r, le_nxt;
  logic [63:0] w_r, w_nxt;
  logic [63:0] f_r, f_nxt;
  logic [62:0] t_r, t_nxt;
  logic [62:0] dp_r, dp_nxt;
  word_t       d_r, d_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [63:0] plo_r, plo_nxt;
  logic [63:0] phi_r, phi_nxt;

  // output register
  logic         out_valid_r, out_valid_nxt;
  logic [239:0] out_data_r, out_data_nxt;
  logic         out_last_r, out_last_nxt;

  // shared multiplier
  logic [63:0] mul_a;
  word_t       mul_b;
  logic [63:0] mul_p;
  logic [95:0] prod;
  logic        is_mul, act;
  logic [32:0] mag_i;

  // combinational temporaries
  logic [63:0] xs;
  logic [5:0]  nsh_s, sh;
  logic [32:0] mm;
  logic [LW-1:0] lr_s;
  logic [63:0] bitv, trial;
  logic [32:0] rem2;
  logic        ge, neg;
  logic [62:0] db;
  logic signed [65:0] dps, dbs, acc_s, sum_s;
  logic        out_free;

  assign mag_i = mag_f(eta_r[idx_r]);
  assign is_mul = (state_r == S_SQ) || (state_r == S_EPS) || (state_r == S_LSQ) ||
                  (state_r == S_LN) || (state_r == S_FRC) || (state_r == S_CAP) ||
                  (state_r == S_T) || (state_r == S_DP) || (state_r == S_DB);
  assign act = is_mul && (ph_r == 2'd2);

  always_comb begin
    unique case (state_r)
      S_SQ: begin
        mul_a = 64'(mag_i);
        mul_b = mag_i[31:0];
      end
      S_EPS: begin
        mul_a = 64'(eps_r);
        mul_b = 32'(eps_r);
      end
      S_LSQ: begin
        mul_a = 64'(m_r);
        mul_b = m_r;
      end
      S_LN: begin
        mul_a = 64'(le_r);
        mul_b = LN2_Q24;
      end
      S_FRC: begin
        mul_a = w_r;
        mul_b = 32'(fscale_r);
      end
      S_CAP: begin
        mul_a = 64'(fscale_r);
        mul_b = CAP_MUL;
      end
      S_T: begin
        mul_a = f_r;
        mul_b = 32'(q_r);
      end
      S_DP: begin
        mul_a = 64'(t_r);
        mul_b = 32'(ipm_r);
      end
      S_DB: begin
        mul_a = 64'(t_r);
        mul_b = 32'(ibm_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // low half in phase 0, high half in phase 1
  assign mul_p = (ph_r[0] ? mul_a[63:32] : mul_a[31:0]) * mul_b;
  assign prod  = {phi_r, 32'd0} + {32'd0, plo_r};

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    lsel_nxt  = lsel_r;
    last_nxt  = last_r;
    eta_nxt   = eta_r;
    acc_nxt   = acc_r;
    sum_nxt   = sum_r;
    d2_nxt    = d2_r;
    x_nxt     = x_r;
    r_nxt     = r_r;
    nsh_nxt   = nsh_r;
    m_nxt     = m_r;
    lr_nxt    = lr_r;
    le_nxt    = le_r;
    w_nxt     = w_r;
    f_nxt     = f_r;
    t_nxt     = t_r;
    dp_nxt    = dp_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    plo_nxt   = plo_r;
    phi_nxt   = phi_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    xs    = x_r;
    nsh_s = nsh_r;
    sh    = 6'd32 >> cnt_r[2:0];
    mm    = prod[63:31];
    lr_s  = lr_r;
    bitv  = 64'd1 << (7'd62 - {cnt_r, 1'b0});
    trial = r_r + bitv;
    rem2  = {rem_r[31:0], 1'b0};
    ge    = rem2 >= {1'b0, d_r};
    neg   = eta_r[idx_r][32];
    db    = sat_f(prod);
    dps   = neg ? -$signed(66'(dp_r)) : $signed(66'(dp_r));
    dbs   = neg ? -$signed(66'(db)) : $signed(66'(db));
    acc_s = clamp_f($signed({{34{acc_r[idx_r][31]}}, acc_r[idx_r]}) - dps, ACC_HI, ACC_LO);
    sum_s = clamp_f($signed(66'(sum_r[idx_r])) + dbs, SUM_HI, SUM_LO);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (is_mul) begin
      if (ph_r == 2'd0) begin
        plo_nxt = mul_p;
        ph_nxt  = 2'd1;
      end else if (ph_r == 2'd1) begin
        phi_nxt = mul_p;
        ph_nxt  = 2'd2;
      end else begin
        ph_nxt = 2'd0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          for (int i = 0; i < 3; i++) begin
            eta_nxt[i] = $signed({center_r[i][31], center_r[i]}) -
                         $signed({in_tdata[32*i+31], in_tdata[32*i +: 32]});
            acc_nxt[i] = in_tdata[96+32*i +: 32];
          end
          last_nxt  = in_tlast;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        d2_nxt  = '0;
        idx_nxt = '0;
        if ((mag_f(eta_r[0]) > 33'(eps_r)) || (mag_f(eta_r[1]) > 33'(eps_r)) ||
            (mag_f(eta_r[2]) > 33'(eps_r))) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (act) begin
          d2_nxt = d2_r + prod[63:0];
          if (idx_r == 2'd2) begin
            state_nxt = S_EPS;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      S_EPS: begin
        if (act) begin
          if ((d2_r == 64'd0) || (d2_r > prod[63:0])) begin
            state_nxt = S_DONE;
          end else begin
            x_nxt     = prod[63:0];
            lsel_nxt  = 1'b0;
            cnt_nxt   = '0;
            nsh_nxt   = '0;
            state_nxt = S_NORM;
          end
        end
      end
      S_NORM: begin
        // binary search for the leading one: 32, 16, 8, 4, 2, 1
        if ((x_r >> (7'd64 - 7'(sh))) == 64'd0) begin
          xs    = x_r << sh;
          nsh_s = nsh_r + sh;
        end
        x_nxt   = xs;
        nsh_nxt = nsh_s;
        if (cnt_r == 6'd5) begin
          m_nxt     = xs[63:32];
          lr_nxt    = LW'(6'd63 - nsh_s) << LOG_FRAC;
          cnt_nxt   = 6'(LOG_FRAC - 1);
          state_nxt = S_LSQ;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_LSQ: begin
        if (act) begin
          if (mm[32]) begin
            m_nxt = mm[32:1];
            lr_s  = lr_r | (LW'(1) << cnt_r);
          end else begin
            m_nxt = mm[31:0];
          end
          lr_nxt = lr_s;
          if (cnt_r == 6'd0) begin
            if (!lsel_r) begin
              le_nxt    = lr_s;
              x_nxt     = d2_r;
              lsel_nxt  = 1'b1;
              nsh_nxt   = '0;
              state_nxt = S_NORM;
            end else begin
              le_nxt    = (le_r > lr_s) ? le_r - lr_s : '0;
              state_nxt = S_LN;
            end
          end else begin
            cnt_nxt = cnt_r - 6'd1;
          end
        end
      end
      S_LN: begin
        if (act) begin
          w_nxt     = prod[63:0] >> LN_SHIFT;
          state_nxt = S_FRC;
        end
      end
      S_FRC: begin
        if (act) begin
          f_nxt     = prod[63:0] >> FRAC_BITS;
          state_nxt = S_CAP;
        end
      end
      S_CAP: begin
        if (act) begin
          if (f_r > prod[63:0]) begin
            f_nxt = prod[63:0];
          end
          x_nxt     = d2_r;
          r_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (x_r >= trial) begin
          x_nxt = x_r - trial;
          r_nxt = (r_r >> 1) + bitv;
        end else begin
          r_nxt = r_r >> 1;
        end
        if (cnt_r == 6'd31) begin
          d_nxt     = r_nxt[31:0];
          idx_nxt   = '0;
          state_nxt = S_DIVI;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_DIVI: begin
        // |eta_i| <= d, so the integer quotient bit is the only one above the fraction
        if (mag_i[31:0] >= d_r) begin
          rem_nxt = 33'(mag_i[31:0] - d_r);
          q_nxt   = QW'(1);
        end else begin
          rem_nxt = 33'(mag_i[31:0]);
          q_nxt   = '0;
        end
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? rem2 - {1'b0, d_r} : rem2;
        q_nxt   = {q_r[QW-2:0], ge};
        if (cnt_r == 6'(FRAC_BITS - 1)) begin
          state_nxt = S_T;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_T: begin
        if (act) begin
          t_nxt     = sat_f(prod);
          state_nxt = S_DP;
        end
      end
      S_DP: begin
        if (act) begin
          dp_nxt    = sat_f(prod);
          state_nxt = S_DB;
        end
      end
      S_DB: begin
        if (act) begin
          acc_nxt[idx_r] = acc_s[31:0];
          sum_nxt[idx_r] = sum_s[SUM_BITS-1:0];
          if (idx_r == 2'd2) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = S_DIVI;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          for (int i = 0; i < 3; i++) begin
            out_data_nxt[32*i +: 32] = acc_r[i];
            out_data_nxt[96+48*i +: 48] =
              48'(clamp_f($signed(66'(sum_r[i])), OUT_HI, OUT_LO));
            if (last_r) begin
              sum_nxt[i] = '0;
            end
          end
          out_last_nxt  = last_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r[0] <= '0;
      center_r[1] <= '0;
      center_r[2] <= '0;
      eps_r       <= CFG_ONE_RST;
      fscale_r    <= CFG_ONE_RST;
      ipm_r       <= CFG_ONE_RST;
      ibm_r       <= CFG_ONE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CENTER_X: center_r[0] <= cfg_wdata;
        CFG_CENTER_Y: center_r[1] <= cfg_wdata;
        CFG_CENTER_Z: center_r[2] <= cfg_wdata;
        CFG_EPS:      eps_r       <= cfg_wdata[30:0];
        CFG_FSCALE:   fscale_r    <= cfg_wdata[30:0];
        CFG_IPM:      ipm_r       <= cfg_wdata[30:0];
        CFG_IBM:      ibm_r       <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= '0;
      out_valid_r <= 1'b0;
      sum_r[0]    <= '0;
      sum_r[1]    <= '0;
      sum_r[2]    <= '0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    lsel_r     <= lsel_nxt;
    last_r     <= last_nxt;
    eta_r      <= eta_nxt;
    acc_r      <= acc_nxt;
    d2_r       <= d2_nxt;
    x_r        <= x_nxt;
    r_r        <= r_nxt;
    nsh_r      <= nsh_nxt;
    m_r        <= m_nxt;
    lr_r       <= lr_nxt;
    le_r       <= le_nxt;
    w_r        <= w_nxt;
    f_r        <= f_nxt;
    t_r        <= t_nxt;
    dp_r       <= dp_nxt;
    d_r        <= d_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    plo_r      <= plo_nxt;
    phi_r      <= phi_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while a particle is in work");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r != 2'd3) && (is_mul || ph_r == 2'd0))
    else $error("multiplier phase out of step with sequencer");

  a_pass_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free && last_r) |=>
      (sum_r[0] == '0 && sum_r[1] == '0 && sum_r[2] == '0 && out_valid_r))
    else $error("body sums not cleared at end of pass");

endmodule

// ----- sim/sphere_particle_contact_force_unit_test.sv -----
`timescale 1ns / 100ps

module sphere_particle_contact_force_unit_test
  import spcf_pkg::*;
;

  localparam int unsigned FRAC = 16;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam longint unsigned PROD_CAP = 64'h4000_0000_0000_0000;
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] acc;
    logic             last;
  } particle_t;

  typedef struct packed {
    logic [2:0][31:0] acc;
    logic [2:0][47:0] body;
    logic             done;
  } contact_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // pos_x, pos_y, pos_z, acc_in_x, acc_in_y, acc_in_z
  logic [191:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // acc_out_x, acc_out_y, acc_out_z, body_acc_x, body_acc_y, body_acc_z
  logic [239:0] out_tdata;
  logic out_tlast;

  // predictor copies of registers and body sums
  logic [31:0] reg_val [7];
  longint body_sum [3];

  contact_result_t expected_q[$];
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int contacts_seen = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  bit holding = 1'b0;
  string axis_name [3] = '{"x", "y", "z"};

  sphere_particle_contact_force_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint unsigned log2_q(longint unsigned x);
    int n;
    longint unsigned m, r;
    if (x == 0) return 0;
    n = 63;
    while (!x[n]) n--;
    m = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
    r = longint'(n) << (FRAC + 4);
    for (int i = FRAC + 3; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mul_capped(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> FRAC;
    return (p > PROD_CAP) ? PROD_CAP : p[63:0];
  endfunction

  function automatic longint clamp(longint v, longint hi);
    return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
  endfunction

  function automatic contact_result_t predict_contact(particle_t p);
    contact_result_t r;
    longint eta [3];
    longint unsigned mag [3];
    longint unsigned eps, d2, le, ld, diff, lnv, frc, cap, d, q, t;
    longint dp, db, a;
    bit act;
    eps = reg_val[CFG_EPS];
    act = 1'b1;
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      eta[i] = longint'($signed(reg_val[i])) - longint'($signed(p.pos[i]));
      mag[i] = (eta[i] < 0) ? -eta[i] : eta[i];
      if (mag[i] > eps) act = 1'b0;
    end
    if (act) begin
      for (int i = 0; i < 3; i++) d2 += mag[i] * mag[i];
      if (d2 == 0 || d2 > eps * eps) act = 1'b0;
    end
    if (act) contacts_seen++;
    if (act) begin
      le = log2_q(eps * eps);
      ld = log2_q(d2);
      diff = (le > ld) ? le - ld : 0;
      lnv = (diff * 64'd11629080) >> LN_SHIFT;
      frc = (longint'(reg_val[CFG_FSCALE]) * lnv) >> FRAC;
      cap = longint'(reg_val[CFG_FSCALE]) * 10000;
      if (frc > cap) frc = cap;
      d = sqrt_floor(d2);
    end
    for (int i = 0; i < 3; i++) begin
      a = longint'($signed(p.acc[i]));
      if (act) begin
        q = (mag[i] << FRAC) / d;
        t = mul_capped(frc, q);
        dp = longint'(mul_capped(t, reg_val[CFG_IPM]));
        db = longint'(mul_capped(t, reg_val[CFG_IBM]));
        if (eta[i] < 0) begin
          dp = -dp;
          db = -db;
        end
        a = a - dp;
        body_sum[i] = clamp(body_sum[i] + db, SUM_HI);
      end
      r.acc[i] = 32'(clamp(a, 64'sh7FFF_FFFF));
      r.body[i] = body_sum[i][47:0];
    end
    r.done = p.last;
    if (p.last) for (int i = 0; i < 3; i++) body_sum[i] = 0;
    return r;
  endfunction

  // sender: random gaps between requests unless no_idle is set
  task automatic send_particle(particle_t p);
    if (!no_idle && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tdata <= {p.acc, p.pos};
    in_tlast <= p.last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(predict_contact(p));
    requests_sent++;
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx[CFG_ADDR_W-1:0];
    cfg_wdata <= v;
    @(posedge clk);
    if (idx < 3) reg_val[idx] = v;
    else if (idx < 7) reg_val[idx] = {1'b0, v[30:0]};
  endtask

  // registers only change while the block is idle
  task automatic load_setting(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] eps, logic [31:0] fs, logic [31:0] ipm,
                              logic [31:0] ibm);
    in_tvalid <= 1'b0;
    wait_idle();
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_EPS, eps);
    write_reg(CFG_FSCALE, fs);
    write_reg(CFG_IPM, ipm);
    write_reg(CFG_IBM, ibm);
    write_reg(7, $urandom());
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // position offset from center: mostly in contact, some outside, some noise
  function automatic particle_t random_particle(bit last);
    particle_t p;
    int mode;
    longint unsigned eps, lim;
    longint e;
    eps = reg_val[CFG_EPS];
    mode = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      p.acc[i] = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(2000) - 1000;
      if (mode < 10) begin
        p.pos[i] = $urandom();
      end else if (mode < 13) begin
        p.pos[i] = reg_val[i];
      end else begin
        lim = (mode < 80) ? eps / 2 : eps + eps / 4 + 1;
        if ($urandom_range(3) == 0) lim = lim / 1000 + 1;
        e = longint'({$urandom(), $urandom()} % (lim + 1));
        if ($urandom_range(1)) e = -e;
        p.pos[i] = reg_val[i] - e[31:0];
      end
    end
    p.last = last;
    return p;
  endfunction

  task automatic send_pass(int n);
    for (int k = 0; k < n; k++) send_particle(random_particle(k == n - 1));
  endtask

  // result checker and output stall generator
  always @(posedge clk) begin
    contact_result_t got, want;
    if (out_tvalid && out_tready) begin
      got.acc = out_tdata[95:0];
      got.body = out_tdata[239:96];
      got.done = out_tlast;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        want = expected_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got.acc[i] !== want.acc[i]) begin
            $error("acc_out_%s: expected %h, got %h", axis_name[i], want.acc[i], got.acc[i]);
            errors++;
          end
          if (got.body[i] !== want.body[i]) begin
            $error("body_acc_%s: expected %h, got %h", axis_name[i], want.body[i],
                   got.body[i]);
            errors++;
          end
        end
        if (got.done !== want.done) begin
          $error("pass_done: expected %b, got %b", want.done, got.done);
          errors++;
        end
      end
    end
    out_tready <= !holding && (no_idle || $urandom_range(99) >= 21);
  end

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  task automatic test_defaults();
    particle_t p;
    // reset values: center 0, eps 1.0; zero distance then two points in contact
    p.acc = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000};
    p.pos = '0;
    p.last = 1'b0;
    send_particle(p);
    p.pos = '{32'h0, 32'h0, 32'h0000_4000};
    send_particle(p);
    p.pos = '{32'h0000_8000, 32'hFFFF_8000, 32'h0000_1000};
    p.last = 1'b1;
    send_particle(p);
    stop_sending();
  endtask

  task automatic test_extremes();
    particle_t p;
    load_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int k = 0; k < 6; k++) begin
      p.pos = '{32'h0, (k[0] ? 32'h7FFF_FFFF : 32'h0), (k[1] ? 32'h8000_0000 : 32'h7FFF_0000)};
      p.acc = '{32'h8000_0000, 32'h7FFF_FFFF, (k[2] ? 32'hFFFF_FFFF : 32'h0)};
      p.last = (k == 5);
      send_particle(p);
    end
    // exact center, then tiny distance for the force cap
    p.pos = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000};
    p.last = 1'b0;
    send_particle(p);
    p.pos = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0001};
    send_particle(p);
    p.last = 1'b1;
    send_particle(p);
    stop_sending();
    // zero contact distance and zero gains
    load_setting(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    p.pos = '{32'h0, 32'hFFFF_0000, 32'h0001_0000};
    send_particle(p);
    p.pos = '{32'h0, 32'hFFFF_0000, 32'h0001_0001};
    send_particle(p);
    stop_sending();
    load_setting(32'h0, 32'h0, 32'h0, 32'h0100_0000, 32'h0, 32'h7FFF_FFFF, 32'h0001_0000);
    send_pass(4);
    stop_sending();
  endtask

  task automatic test_random_passes(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      int n;
      if ($urandom_range(9) == 0)
        load_setting($urandom(), $urandom(), $urandom(), $urandom_range(32'h7FFF_FFFF),
                     $urandom_range(32'h0010_0000), $urandom_range(32'h0004_0000),
                     $urandom_range(32'h0001_0000));
      n = $urandom_range(8, 1);
      no_idle = ($urandom_range(7) == 0);
      send_pass(n);
      sent += n;
    end
    no_idle = 1'b0;
    stop_sending();
  endtask

  task automatic test_backpressure();
    load_setting(32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h0008_0000, 32'h0003_0000,
                 32'h0002_0000, 32'h0000_4000);
    hold_req = 1'b1;
    no_idle = 1'b1;
    send_pass(12);
    no_idle = 1'b0;
    stop_sending();
    // sender pauses until everything is back
    wait_idle();
    send_pass(5);
    stop_sending();
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      reg_val[i] = '0;
      body_sum[i] = 0;
    end
    for (int i = 3; i < 7; i++) reg_val[i] = {1'b0, CFG_ONE_RST};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_extremes();
    test_random_passes(550);
    test_backpressure();
    load_setting(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 32'h0001_0000);
    test_random_passes(600);
    wait_idle();
    repeat (300) @(posedge clk);
    $display("Sent %0d particle requests, checked %0d results, %0d in contact.",
             requests_sent, results_seen, contacts_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
